### rtl/sat_pkg.sv
// Shared types and constants for the segment allocator.
`default_nettype none
package sat_pkg;

    // Table geometry and field widths
    localparam int MAX_SEGMENTS = 16;
    localparam int ADDR_BITS    = 16;
    localparam int OWNER_W      = 8;
    localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    // Managed memory size after reset
    localparam logic [ADDR_BITS-1:0] TOTAL_RESET = {ADDR_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_FIRST   = 2'd0,
        OP_BEST    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_OWNER = 2'd3
    } t_status;

    // Command transaction
    typedef struct packed {
        t_op                  operation;
        logic [OWNER_W-1:0]   owner_id;
        logic [ADDR_BITS-1:0] request_size;
    } t_in;

    // Result transaction
    typedef struct packed {
        t_status              status;
        logic [ADDR_BITS-1:0] segment_address;
        logic [ADDR_BITS-1:0] free_total;
        logic [ADDR_BITS-1:0] used_total;
    } t_out;

    // One segment table entry
    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] len;
        logic                 busy;
        logic [OWNER_W-1:0]   owner;
    } t_seg;

    // Table write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_seg             data;
    } t_wr;

endpackage
`default_nettype wire

### rtl/sat_table.sv
// Segment table register file: one read port, two write ports, entry 0 init.
`default_nettype none
module sat_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_init,
    input  wire logic [sat_pkg::ADDR_BITS-1:0] i_init_len,
    input  wire logic [sat_pkg::IDX_W-1:0]     i_rd_addr,
    output sat_pkg::t_seg                      o_rd_data,
    input  wire sat_pkg::t_wr                  i_wr0,
    input  wire sat_pkg::t_wr                  i_wr1
);

    sat_pkg::t_seg r_tab [sat_pkg::MAX_SEGMENTS];

    // Read the entry the sequencer points at
    assign o_rd_data = r_tab[i_rd_addr];

    // Seed entry 0 on reset or size write, otherwise take the write ports
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab[0].base  <= '0;
            r_tab[0].len   <= sat_pkg::TOTAL_RESET;
            r_tab[0].busy  <= 1'b0;
            r_tab[0].owner <= '0;
        end else if (i_init) begin
            r_tab[0].base  <= '0;
            r_tab[0].len   <= i_init_len;
            r_tab[0].busy  <= 1'b0;
            r_tab[0].owner <= '0;
        end else begin
            if (i_wr0.en) begin
                r_tab[i_wr0.addr] <= i_wr0.data;
            end
            if (i_wr1.en) begin
                r_tab[i_wr1.addr] <= i_wr1.data;
            end
        end
    end

    // Split writes two neighbors, never the same entry twice
    a_wr_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr0.en && i_wr1.en) |-> (i_wr0.addr != i_wr1.addr))
        else $error("both table write ports hit one entry");

endmodule
`default_nettype wire

### rtl/segment_allocator_first_best_fit.sv
// Segment allocator top level: sequencer, shared adder and running totals.
// Allocate (first or best fit): start, scan, check, then shift and split if needed, then the totals;
//   the scan reads one entry a cycle, then a split shifts the upper entries one a cycle.
// Release: a read step and a merge step per entry, then a final write and, if anything was released, the totals.
// Zero-size allocate and the unused operation code answer on the next cycle.
// One transaction at a time while busy is high; the result strobe lasts one cycle, no stall.
// Reset (synchronous, active low) leaves one free segment of 65535 units; a size write re-seeds.
`default_nettype none
module segment_allocator_first_best_fit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire sat_pkg::t_in                  i_cmd,
    output logic                               busy,
    output logic                               o_done,
    output sat_pkg::t_out                      o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [sat_pkg::ADDR_BITS-1:0] i_cfg_wdata
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_SCAN    = 11'b000_0000_0010,
        S_CHECK   = 11'b000_0000_0100,
        S_SHIFT   = 11'b000_0000_1000,
        S_SPLIT   = 11'b000_0001_0000,
        S_FREE    = 11'b000_0010_0000,
        S_USED    = 11'b000_0100_0000,
        S_REL_RD  = 11'b000_1000_0000,
        S_REL_MRG = 11'b001_0000_0000,
        S_REL_END = 11'b010_0000_0000,
        S_SPARE   = 11'b100_0000_0000
    } t_state;

    localparam int AW = sat_pkg::ADDR_BITS;
    localparam int IW = sat_pkg::IDX_W;
    localparam int CW = sat_pkg::CNT_W;

    t_state                      r_state, n_state;
    logic                        r_best, r_is_rel;
    logic [sat_pkg::OWNER_W-1:0] r_owner;
    logic [AW-1:0]               r_size;
    logic [IW-1:0]               r_idx, r_pick;
    logic                        r_found, r_hit;
    logic [AW-1:0]               r_pick_base, r_left, r_addr, r_rel_sum;
    logic [AW-1:0]               r_free, r_used;
    logic [CW-1:0]               r_count, r_w;
    sat_pkg::t_seg               r_cur, r_hold;
    logic                        r_done;
    sat_pkg::t_out               r_result;

    sat_pkg::t_seg               rd;
    logic [IW-1:0]               rd_addr;
    sat_pkg::t_wr                wr0, wr1;
    logic [AW-1:0]               alu_a, alu_b, alu_b_in;
    logic                        alu_sub;
    logic [AW:0]                 alu_y;
    logic                        fits, take, last, merge, match, full;
    logic [IW-1:0]               pick_nx, w_idx;
    logic [CW-1:0]               w_dec, cnt_dec;

    // Table storage
    sat_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (i_cfg_we),
        .i_init_len (i_cfg_wdata),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd),
        .i_wr0      (wr0),
        .i_wr1      (wr1)
    );

    // Point the read port: shifting reads the entry below the one written
    assign rd_addr = (r_state == S_SHIFT) ? (r_idx - IW'(1)) : r_idx;

    // Select operands for the shared adder
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_SCAN: begin
                alu_a   = rd.len;
                alu_b   = r_size;
                alu_sub = 1'b1;
            end
            S_SPLIT: begin
                alu_a = r_pick_base;
                alu_b = r_size;
            end
            S_FREE: begin
                alu_a   = r_free;
                alu_b   = r_is_rel ? r_rel_sum : r_size;
                alu_sub = !r_is_rel;
            end
            S_USED: begin
                alu_a   = r_used;
                alu_b   = r_is_rel ? r_rel_sum : r_size;
                alu_sub = r_is_rel;
            end
            S_REL_RD: begin
                alu_a = r_rel_sum;
                alu_b = rd.len;
            end
            S_REL_MRG: begin
                alu_a = r_hold.len;
                alu_b = r_cur.len;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_b_in = alu_sub ? ~alu_b : alu_b;
    assign alu_y    = {1'b0, alu_a} + {1'b0, alu_b_in} + (AW + 1)'(alu_sub);

    // Scan and merge decisions
    assign cnt_dec = r_count - CW'(1);
    assign last    = (CW'(r_idx) == cnt_dec);
    assign fits    = !rd.busy && alu_y[AW];
    assign take    = fits && (!r_best || !r_found || (alu_y[AW-1:0] < r_left));
    assign full    = (r_count >= CW'(sat_pkg::MAX_SEGMENTS));
    assign pick_nx = r_pick + IW'(1);
    assign w_dec   = r_w - CW'(1);
    assign w_idx   = w_dec[IW-1:0];
    assign match   = rd.busy && (rd.owner == r_owner);
    assign merge   = (r_w != '0) && !r_hold.busy && !r_cur.busy;

    // Drive table writes
    always_comb begin
        wr0 = '0;
        wr1 = '0;
        case (r_state)
            S_CHECK: begin
                if (r_found && (r_left == '0)) begin
                    wr0.en         = 1'b1;
                    wr0.addr       = r_pick;
                    wr0.data.base  = r_pick_base;
                    wr0.data.len   = r_size;
                    wr0.data.busy  = 1'b1;
                    wr0.data.owner = r_owner;
                end
            end
            S_SHIFT: begin
                wr0.en   = 1'b1;
                wr0.addr = r_idx;
                wr0.data = rd;
            end
            S_SPLIT: begin
                wr0.en         = 1'b1;
                wr0.addr       = r_pick;
                wr0.data.base  = r_pick_base;
                wr0.data.len   = r_size;
                wr0.data.busy  = 1'b1;
                wr0.data.owner = r_owner;
                wr1.en         = 1'b1;
                wr1.addr       = pick_nx;
                wr1.data.base  = alu_y[AW-1:0];
                wr1.data.len   = r_left;
                wr1.data.busy  = 1'b0;
                wr1.data.owner = r_owner;
            end
            S_REL_MRG: begin
                if (!merge && (r_w != '0)) begin
                    wr0.en   = 1'b1;
                    wr0.addr = w_idx;
                    wr0.data = r_hold;
                end
            end
            S_REL_END: begin
                wr0.en   = 1'b1;
                wr0.addr = w_idx;
                wr0.data = r_hold;
            end
            default: begin
                wr0 = '0;
                wr1 = '0;
            end
        endcase
    end

    // Sequence the operation
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd.operation)
                        sat_pkg::OP_FIRST,
                        sat_pkg::OP_BEST:    n_state = (i_cmd.request_size != '0) ? S_SCAN : S_IDLE;
                        sat_pkg::OP_RELEASE: n_state = S_REL_RD;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if ((take && !r_best) || last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!r_found) begin
                    n_state = S_IDLE;
                end else if (r_left == '0) begin
                    n_state = S_FREE;
                end else if (full) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (r_idx == pick_nx) begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT:   n_state = S_FREE;
            S_FREE:    n_state = S_USED;
            S_USED:    n_state = S_IDLE;
            S_REL_RD:  n_state = S_REL_MRG;
            S_REL_MRG: n_state = last ? S_REL_END : S_REL_RD;
            S_REL_END: n_state = r_hit ? S_FREE : S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_count <= CW'(1);
            r_free  <= sat_pkg::TOTAL_RESET;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;

            // Re-seed totals on a size write
            if (i_cfg_we) begin
                r_count <= CW'(1);
                r_free  <= i_cfg_wdata;
                r_used  <= '0;
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_best    <= (i_cmd.operation == sat_pkg::OP_BEST);
                        r_is_rel  <= (i_cmd.operation == sat_pkg::OP_RELEASE);
                        r_owner   <= i_cmd.owner_id;
                        r_size    <= i_cmd.request_size;
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_hit     <= 1'b0;
                        r_rel_sum <= '0;
                        r_w       <= '0;
                        r_addr    <= '0;
                        r_result.segment_address <= '0;
                        r_result.free_total      <= r_free;
                        r_result.used_total      <= r_used;
                        case (i_cmd.operation)
                            sat_pkg::OP_FIRST,
                            sat_pkg::OP_BEST: begin
                                if (i_cmd.request_size == '0) begin
                                    r_done          <= 1'b1;
                                    r_result.status <= sat_pkg::ST_NO_FIT;
                                end
                            end
                            sat_pkg::OP_RELEASE: begin
                                r_result.status <= sat_pkg::ST_OK;
                            end
                            default: begin
                                r_done          <= 1'b1;
                                r_result.status <= sat_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (take) begin
                        r_pick      <= r_idx;
                        r_pick_base <= rd.base;
                        r_left      <= alu_y[AW-1:0];
                        r_found     <= 1'b1;
                    end
                    if (!last) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_CHECK: begin
                    r_addr <= r_pick_base;
                    if (!r_found || ((r_left != '0) && full)) begin
                        r_done                   <= 1'b1;
                        r_result.status          <= r_found ? sat_pkg::ST_FULL : sat_pkg::ST_NO_FIT;
                        r_result.segment_address <= '0;
                        r_result.free_total      <= r_free;
                        r_result.used_total      <= r_used;
                    end else if (r_left != '0) begin
                        r_idx <= r_count[IW-1:0];
                    end
                end
                S_SHIFT: begin
                    r_idx <= r_idx - IW'(1);
                end
                S_SPLIT: begin
                    r_count <= r_count + CW'(1);
                end
                S_FREE: begin
                    r_free <= alu_y[AW-1:0];
                end
                S_USED: begin
                    r_used                   <= alu_y[AW-1:0];
                    r_done                   <= 1'b1;
                    r_result.status          <= sat_pkg::ST_OK;
                    r_result.segment_address <= r_addr;
                    r_result.free_total      <= r_free;
                    r_result.used_total      <= alu_y[AW-1:0];
                end
                S_REL_RD: begin
                    // Clear the owner's busy flag and add up released units
                    if (match) begin
                        if (!r_hit) begin
                            r_addr <= rd.base;
                        end
                        r_hit     <= 1'b1;
                        r_rel_sum <= alu_y[AW-1:0];
                    end
                    r_cur      <= rd;
                    r_cur.busy <= rd.busy && !match;
                end
                S_REL_MRG: begin
                    // Fold a free entry into a free predecessor, else advance the write slot
                    if (merge) begin
                        r_hold.len <= alu_y[AW-1:0];
                    end else begin
                        r_hold <= r_cur;
                        r_w    <= r_w + CW'(1);
                    end
                    if (!last) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_REL_END: begin
                    if (r_hit) begin
                        r_count <= r_w;
                    end else begin
                        r_done                   <= 1'b1;
                        r_result.status          <= sat_pkg::ST_NO_OWNER;
                        r_result.segment_address <= '0;
                        r_result.free_total      <= r_free;
                        r_result.used_total      <= r_used;
                    end
                end
                default: begin
                    r_done <= 1'b0;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    // Segment count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(sat_pkg::MAX_SEGMENTS)))
        else $error("segment count out of range");

    // A result is only shown once the sequencer is back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted transaction either answers at once or keeps the block busy
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_we) |=> (busy || o_done))
        else $error("accepted transaction dropped");

    // Shifting only happens with a free slot at the top of the table
    a_shift_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_count < CW'(sat_pkg::MAX_SEGMENTS)))
        else $error("shift with a full table");

    // Failed transactions report address zero
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != sat_pkg::ST_OK)) |-> (o_result.segment_address == '0))
        else $error("nonzero address on failure");

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the segment allocator: directed and random commands.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sat_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 115;

    typedef enum {ITEM_CMD, ITEM_CFG, ITEM_DRAIN} item_kind_e;

    typedef struct {
        item_kind_e           kind;
        t_in                  cmd;
        logic [ADDR_BITS-1:0] mem_size;
        int                   gap;
    } stim_item_t;

    typedef struct {
        t_out   res;
        longint stamp;
    } awaited_t;

    // DUT connections, known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    t_in                  i_cmd       = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [ADDR_BITS-1:0] i_cfg_wdata = '0;
    logic                 busy;
    logic                 o_done;
    t_out                 o_result;

    // Shadow copy of the segment table
    logic [ADDR_BITS-1:0] tbl_base  [MAX_SEGMENTS];
    logic [ADDR_BITS-1:0] tbl_len   [MAX_SEGMENTS];
    logic                 tbl_busy  [MAX_SEGMENTS];
    logic [OWNER_W-1:0]   tbl_owner [MAX_SEGMENTS];
    int                   tbl_count;
    logic [ADDR_BITS-1:0] units_free;
    logic [ADDR_BITS-1:0] units_used;

    stim_item_t cmd_queue[$];
    awaited_t   awaited_results[$];
    int         in_flight;
    int         gap_left;
    int         fail_cnt;
    int         cycle_cnt;
    bit         burst;

    segment_allocator_first_best_fit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Re-seed the table as one free segment covering the whole memory
    function automatic void seed_table(logic [ADDR_BITS-1:0] size);
        int i;
        for (i = 0; i < MAX_SEGMENTS; i++) begin
            tbl_base[i]  = '0;
            tbl_len[i]   = '0;
            tbl_busy[i]  = 1'b0;
            tbl_owner[i] = '0;
        end
        tbl_len[0] = size;
        tbl_count  = 1;
        units_free = size;
        units_used = '0;
    endfunction

    // Apply one command to the shadow table and return the result it yields
    function automatic t_out apply_command(t_in c);
        t_out                 r;
        int                   pick;
        int                   i;
        int                   w;
        bit                   hit;
        logic [ADDR_BITS-1:0] left;
        logic [ADDR_BITS-1:0] left_min;
        r.status          = ST_OK;
        r.segment_address = '0;
        pick              = -1;
        left_min          = '0;
        hit               = 1'b0;
        case (c.operation)
            OP_FIRST, OP_BEST: begin
                if (c.request_size == 0) begin
                    r.status = ST_NO_FIT;
                end else begin
                    // scan for the lowest fitting segment or the tightest leftover
                    for (i = 0; i < tbl_count; i++) begin
                        if (!tbl_busy[i] && tbl_len[i] >= c.request_size) begin
                            left = tbl_len[i] - c.request_size;
                            if (pick < 0 || (c.operation == OP_BEST && left < left_min)) begin
                                pick     = i;
                                left_min = left;
                            end
                            if (c.operation == OP_FIRST) break;
                        end
                    end
                    if (pick < 0) begin
                        r.status = ST_NO_FIT;
                    end else if (tbl_len[pick] != c.request_size && tbl_count >= MAX_SEGMENTS) begin
                        r.status = ST_FULL;
                    end else begin
                        // split: allocated part first, free rest behind it
                        if (tbl_len[pick] != c.request_size) begin
                            for (i = tbl_count; i > pick; i--) begin
                                tbl_base[i]  = tbl_base[i-1];
                                tbl_len[i]   = tbl_len[i-1];
                                tbl_busy[i]  = tbl_busy[i-1];
                                tbl_owner[i] = tbl_owner[i-1];
                            end
                            tbl_count++;
                            tbl_len[pick]    = c.request_size;
                            tbl_base[pick+1] = tbl_base[pick+1] + c.request_size;
                            tbl_len[pick+1]  = tbl_len[pick+1] - c.request_size;
                        end
                        tbl_busy[pick]    = 1'b1;
                        tbl_owner[pick]   = c.owner_id;
                        units_free        = units_free - c.request_size;
                        units_used        = units_used + c.request_size;
                        r.segment_address = tbl_base[pick];
                    end
                end
            end
            OP_RELEASE: begin
                // free every segment of the owner
                for (i = 0; i < tbl_count; i++) begin
                    if (tbl_busy[i] && tbl_owner[i] == c.owner_id) begin
                        if (!hit) r.segment_address = tbl_base[i];
                        hit          = 1'b1;
                        tbl_busy[i]  = 1'b0;
                        tbl_owner[i] = '0;
                        units_free   = units_free + tbl_len[i];
                        units_used   = units_used - tbl_len[i];
                    end
                end
                if (!hit) begin
                    r.status = ST_NO_OWNER;
                end else begin
                    // compact: merge each free segment into a free left neighbor
                    w = 0;
                    for (i = 0; i < tbl_count; i++) begin
                        if (w > 0 && !tbl_busy[w-1] && !tbl_busy[i]) begin
                            tbl_len[w-1] = tbl_len[w-1] + tbl_len[i];
                        end else begin
                            tbl_base[w]  = tbl_base[i];
                            tbl_len[w]   = tbl_len[i];
                            tbl_busy[w]  = tbl_busy[i];
                            tbl_owner[w] = tbl_owner[i];
                            w++;
                        end
                    end
                    tbl_count = w;
                end
            end
            default: ;
        endcase
        r.free_total = units_free;
        r.used_total = units_used;
        return r;
    endfunction

    function automatic void check_field(string field, logic [ADDR_BITS-1:0] want,
                                        logic [ADDR_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            fail_cnt++;
        end
    endfunction

    // Stimulus queue helpers
    function automatic void add_cmd(t_op op, int owner, int size);
        stim_item_t it;
        if ($urandom_range(0, 19) == 0) burst = !burst;
        it.kind                 = ITEM_CMD;
        it.cmd.operation        = op;
        it.cmd.owner_id         = owner[OWNER_W-1:0];
        it.cmd.request_size     = size[ADDR_BITS-1:0];
        it.mem_size             = '0;
        it.gap                  = burst ? 0 : $urandom_range(0, 3);
        cmd_queue.push_back(it);
    endfunction

    function automatic void add_ctl(item_kind_e kind, int size);
        stim_item_t it;
        it.kind     = kind;
        it.cmd      = '0;
        it.mem_size = size[ADDR_BITS-1:0];
        it.gap      = 0;
        cmd_queue.push_back(it);
    endfunction

    // Mostly well-formed traffic on a small owner pool, with some noise
    function automatic void add_random_item(int mem, int pool_lo);
        int pick;
        int limit;
        int size;
        pick  = $urandom_range(0, 99);
        limit = (mem / 6 > 0) ? mem / 6 : 1;
        size  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, (mem > 0) ? mem : 8)
                                            : $urandom_range(1, limit);
        if (pick < 35) begin
            add_cmd(OP_FIRST, pool_lo + $urandom_range(0, 5), size);
        end else if (pick < 60) begin
            add_cmd(OP_BEST, pool_lo + $urandom_range(0, 5), size);
        end else if (pick < 88) begin
            add_cmd(OP_RELEASE, pool_lo + $urandom_range(0, 5), $urandom_range(0, 65535));
        end else begin
            case ($urandom_range(0, 3))
                0: add_cmd(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 65535));
                1: add_cmd(t_op'($urandom_range(0, 1)), $urandom_range(0, 255), 0);
                2: add_cmd(t_op'($urandom_range(0, 1)), $urandom_range(0, 255),
                           $urandom_range(0, 65535));
                default: add_cmd(OP_RELEASE, $urandom_range(0, 255), $urandom_range(0, 65535));
            endcase
        end
        if ($urandom_range(0, 99) == 0) add_ctl(ITEM_DRAIN, 0);
    endfunction

    // Driver: issue commands and size writes, predict each accepted transaction
    always @(posedge i_clk) begin : drive_proc
        stim_item_t           nxt;
        awaited_t             aw;
        logic                 drv_start;
        logic                 drv_we;
        t_in                  drv_cmd;
        logic [ADDR_BITS-1:0] drv_wdata;
        drv_start = start;
        drv_cmd   = i_cmd;
        drv_we    = 1'b0;
        drv_wdata = i_cfg_wdata;
        if (!i_rst_n) begin
            drv_start = 1'b0;
            in_flight = 0;
            gap_left  = 0;
        end else begin
            if (o_done) in_flight--;
            if (start && !busy) begin
                aw.res   = apply_command(i_cmd);
                aw.stamp = $time;
                awaited_results.push_back(aw);
                in_flight++;
                drv_start = 1'b0;
            end
            if (!drv_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_queue.size() > 0) begin
                    nxt = cmd_queue[0];
                    case (nxt.kind)
                        ITEM_CMD: begin
                            drv_start = 1'b1;
                            drv_cmd   = nxt.cmd;
                            gap_left  = nxt.gap;
                            void'(cmd_queue.pop_front());
                        end
                        ITEM_CFG: begin
                            // write the size only with the block idle
                            if (in_flight == 0 && !busy) begin
                                drv_we    = 1'b1;
                                drv_wdata = nxt.mem_size;
                                seed_table(nxt.mem_size);
                                void'(cmd_queue.pop_front());
                            end
                        end
                        default: begin
                            // hold off until every result is back
                            if (in_flight == 0) void'(cmd_queue.pop_front());
                        end
                    endcase
                end
            end
        end
        start       <= drv_start;
        i_cmd       <= drv_cmd;
        i_cfg_we    <= drv_we;
        i_cfg_wdata <= drv_wdata;
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : check_proc
        awaited_t head;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0 || awaited_results[0].stamp >= $time) begin
                $display("%0t: unexpected result: status %0d addr %0d free %0d used %0d",
                         $time, o_result.status, o_result.segment_address,
                         o_result.free_total, o_result.used_total);
                fail_cnt++;
            end else begin
                head = awaited_results.pop_front();
                check_field("status", ADDR_BITS'(head.res.status),
                            ADDR_BITS'(o_result.status));
                check_field("segment_address", head.res.segment_address,
                            o_result.segment_address);
                check_field("free_total", head.res.free_total, o_result.free_total);
                check_field("used_total", head.res.used_total, o_result.used_total);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stim_proc
        int p;
        int n;
        int mem;
        fail_cnt  = 0;
        cycle_cnt = 0;
        burst     = 1'b0;
        seed_table(TOTAL_RESET);

        // Directed: split, zero size, unused opcode, unknown owner, exact fit, merges
        add_cmd(OP_FIRST, 1, 100);
        add_cmd(OP_BEST, 2, 200);
        add_cmd(OP_FIRST, 3, 0);
        add_cmd(OP_NONE, 255, 65535);
        add_cmd(OP_RELEASE, 9, 0);
        add_cmd(OP_RELEASE, 1, 0);
        add_cmd(OP_BEST, 0, 100);
        add_cmd(OP_RELEASE, 2, 0);
        add_cmd(OP_RELEASE, 0, 0);

        // Directed: fill the table, then a split that finds no room and an exact fit
        add_ctl(ITEM_CFG, 17);
        for (n = 1; n <= 15; n++) add_cmd((n % 2) ? OP_FIRST : OP_BEST, n, 1);
        add_cmd(OP_FIRST, 16, 1);
        add_cmd(OP_BEST, 17, 2);

        // Directed: empty memory never fits
        add_ctl(ITEM_CFG, 0);
        add_cmd(OP_FIRST, 1, 1);

        // Random phases over a spread of memory sizes
        for (p = 0; p < 10; p++) begin
            case (p)
                0, 5, 9: mem = 65535;
                1:       mem = 1;
                3:       mem = 0;
                4:       mem = $urandom_range(16, 400);
                7:       mem = $urandom_range(2, 64);
                default: mem = $urandom_range(1, 65535);
            endcase
            add_ctl(ITEM_CFG, mem);
            for (n = 0; n < ((mem == 0) ? 10 : PHASE_ITEMS); n++) begin
                add_random_item(mem, $urandom_range(0, 250));
                if (n == PHASE_ITEMS / 2) add_ctl(ITEM_DRAIN, 0);
            end
        end

        // Release reset and wait for the traffic to drain
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_queue.size() != 0 || start || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (awaited_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
